### rtl/mcrq_pkg.sv
// ----------------------------------------------------------------------------
// Ready queue scheduler package
// Shared types, command and result codes, and register indexes for the
// multi-CPU ready queue scheduler.
// ----------------------------------------------------------------------------
package mcrq_pkg;

    // Built sizes used as parameter defaults on the top level.
    localparam int NUM_CPUS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int ID_BITS_DEF     = 8;

    // Width of a priority value.
    localparam int PRIO_BITS = 4;

    // Commands carried by an input transaction.
    localparam logic [2:0] CMD_WAKE    = 3'd0;
    localparam logic [2:0] CMD_PREEMPT = 3'd1;
    localparam logic [2:0] CMD_YIELD   = 3'd2;
    localparam logic [2:0] CMD_TERM    = 3'd3;
    localparam logic [2:0] CMD_IDLE    = 3'd4;

    // Kinds of result transaction.
    localparam logic [1:0] KIND_DISPATCH = 2'd0;
    localparam logic [1:0] KIND_IDLE     = 2'd1;
    localparam logic [1:0] KIND_PREEMPT  = 2'd2;
    localparam logic [1:0] KIND_DROP     = 2'd3;

    // Scheduling modes; the unused code behaves as FIFO.
    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SLICE = 2'd1;
    localparam logic [1:0] REG_CPUS  = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [2:0] command;
        logic [1:0] cpu;
        logic [7:0] process_id;
        logic [3:0] priority_req;
    } t_cmd;

    // Result transaction.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  target_cpu;
        logic [7:0]  dispatched_id;
        logic [15:0] slice_length;
    } t_res;

endpackage

### rtl/multi_cpu_ready_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Multi-CPU ready queue scheduler
// Ready queue and dispatcher for several CPUs in FIFO, round robin or static
// priority mode, driven by one small sequencer around a queue RAM.
// ----------------------------------------------------------------------------
// Usage: an event transaction is taken when start is high and busy is low.
// While busy is high the block works on that event and takes no other.
// A result, if the event gives one, appears on o_res for exactly one cycle
// with o_valid high; the receiver cannot stall it, so it must take it then.
// The configuration port writes a register; write it only while
// the block is idle.
// Handling: a queue-full drop, an idle dispatch on an empty queue and an
// ignored event finish without raising busy. A dispatch from the queue
// passes through the head-use state. A wake-up in FIFO or round robin mode
// writes the tail, then feeds a waiting CPU from the head if there is one.
// In priority mode the sorted insert scans the queue from its head for the
// insert point and then moves the entries behind it up from the tail, one
// read and one write per entry; the wake-up then feeds a waiting CPU or,
// with every CPU in use running, checks them in turn for a preempt.
// A preempt with requeue pops the head, then inserts the preempted process.
// Reset: the queue is empty, no CPU runs or waits, and the registers take
// FIFO mode, a slice of 1 and four CPUs. No clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_cpu_ready_queue_scheduler_unit #(
    parameter int NUM_CPUS    = mcrq_pkg::NUM_CPUS_DEF,
    parameter int QUEUE_DEPTH = mcrq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mcrq_pkg::ID_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mcrq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output mcrq_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_addr,
    input  logic [15:0]    i_cfg_wdata
);

    localparam int PB   = mcrq_pkg::PRIO_BITS;
    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int NW   = $clog2(NUM_CPUS + 1);
    localparam int WW   = ID_BITS + PB;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b00000001,
        S_INS_RD    = 8'b00000010,
        S_INS_CMP   = 8'b00000100,
        S_WAKE_POST = 8'b00001000,
        S_HEAD_USE  = 8'b00010000,
        S_MIN       = 8'b00100000,
        S_SCAN_RD   = 8'b01000000,
        S_SCAN_CMP  = 8'b10000000
    } t_state;

    // Logical queue position to RAM address, wrapping past the end.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CNTW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, head} + (AW+1)'(pos);
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Builds one result transaction.
    function automatic mcrq_pkg::t_res f_res(input logic [1:0] kind,
                                             input logic [CW-1:0] cpu,
                                             input logic [ID_BITS-1:0] id,
                                             input logic [15:0] slice);
        mcrq_pkg::t_res r;
        r.result_kind   = kind;
        r.target_cpu    = 2'(cpu);
        r.dispatched_id = 8'(id);
        r.slice_length  = slice;
        return r;
    endfunction

    t_state               r_state, n_state;
    logic [CNTW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]        r_head, n_head;
    logic [CNTW-1:0]      r_k, n_k;
    logic [CNTW-1:0]      r_pos, n_pos;
    logic [ID_BITS-1:0]   r_ins_id, n_ins_id;
    logic [PB-1:0]        r_ins_prio, n_ins_prio;
    logic                 r_post_wake, n_post_wake;
    logic                 r_pre, n_pre;
    logic [ID_BITS-1:0]   r_cur_id, n_cur_id;
    logic [PB-1:0]        r_cur_prio, n_cur_prio;
    logic [CW-1:0]        r_tcpu, n_tcpu;
    logic [CW-1:0]        r_ci, n_ci;
    logic [PB:0]          r_min, n_min;
    logic [CW-1:0]        r_best, n_best;
    logic [NUM_CPUS-1:0]  r_running, n_running;
    logic [NUM_CPUS-1:0]  r_waiting, n_waiting;
    logic                 r_valid, n_valid;
    mcrq_pkg::t_res       r_res, n_res;
    logic [1:0]           r_mode;
    logic [15:0]          r_slice;
    logic [2:0]           r_ccount;

    logic [ID_BITS-1:0]   r_proc  [NUM_CPUS];
    logic [PB-1:0]        r_cprio [NUM_CPUS];

    logic                 cpu_we;
    logic [CW-1:0]        cpu_widx;
    logic [ID_BITS-1:0]   cpu_wid;
    logic [PB-1:0]        cpu_wprio;
    logic [CW-1:0]        cpu_ridx;
    logic [ID_BITS-1:0]   cpu_rid;
    logic [PB-1:0]        cpu_rprio;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WW-1:0]        ram_rdata;

    logic [NW-1:0]        n_eff;
    logic [NUM_CPUS-1:0]  act;
    logic [NUM_CPUS-1:0]  wv;
    logic [CW-1:0]        widx;
    logic [15:0]          slice;
    logic [CW-1:0]        in_cpu;
    logic                 cpu_ok;
    logic [ID_BITS-1:0]   h_id;
    logic [PB-1:0]        h_prio;

    // Queue storage: entries hold the process id above its priority.
    mcrq_ram #(
        .WIDTH (WW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign h_id   = ram_rdata[WW-1:PB];
    assign h_prio = ram_rdata[PB-1:0];

    // Effective CPU count, clamped to the built range.
    always_comb begin
        if (r_ccount == 3'd0) begin
            n_eff = NW'(1);
        end else if (32'(r_ccount) > NUM_CPUS) begin
            n_eff = NW'(NUM_CPUS);
        end else begin
            n_eff = NW'(r_ccount);
        end
    end

    for (genvar g = 0; g < NUM_CPUS; g++) begin : g_act
        assign act[g] = 32'(n_eff) > g;
    end

    // Lowest-numbered waiting CPU in use.
    assign wv = r_waiting & act;
    always_comb begin
        widx = '0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (wv[i]) begin
                widx = CW'(i);
            end
        end
    end

    assign slice  = (r_mode == mcrq_pkg::MODE_RR) ? r_slice : 16'd0;
    assign in_cpu = CW'(i_cmd.cpu);
    assign cpu_ok = 32'(i_cmd.cpu) < 32'(n_eff);

    // One read index into the per-CPU tables.
    assign cpu_ridx  = (r_state == S_IDLE) ? in_cpu : r_ci;
    assign cpu_rid   = r_proc[cpu_ridx];
    assign cpu_rprio = r_cprio[cpu_ridx];

    // Read address: the scanned entry, the entry just before the slot that the
    // shift walk fills next, otherwise the head.
    assign ram_raddr = (r_state == S_SCAN_RD) ? f_phys(r_head, r_pos) :
                       (r_state == S_INS_RD && r_k != '0) ?
                       f_phys(r_head, r_k - CNTW'(1)) : r_head;

    // Sequencer.
    always_comb begin
        logic [PB:0] m;
        logic [CW-1:0] b;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_head      = r_head;
        n_k         = r_k;
        n_pos       = r_pos;
        n_ins_id    = r_ins_id;
        n_ins_prio  = r_ins_prio;
        n_post_wake = r_post_wake;
        n_pre       = r_pre;
        n_cur_id    = r_cur_id;
        n_cur_prio  = r_cur_prio;
        n_tcpu      = r_tcpu;
        n_ci        = r_ci;
        n_min       = r_min;
        n_best      = r_best;
        n_running   = r_running;
        n_waiting   = r_waiting;
        n_valid     = 1'b0;
        n_res       = r_res;
        cpu_we      = 1'b0;
        cpu_widx    = r_tcpu;
        cpu_wid     = r_cur_id;
        cpu_wprio   = r_cur_prio;
        ram_we      = 1'b0;
        ram_waddr   = f_phys(r_head, r_k);
        ram_wdata   = {r_ins_id, r_ins_prio};
        m           = r_min;
        b           = r_best;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd.command == mcrq_pkg::CMD_WAKE) begin
                        if (r_cnt == CNTW'(QUEUE_DEPTH)) begin
                            // Full queue: the wake-up is dropped and flagged.
                            n_valid = 1'b1;
                            n_res   = f_res(mcrq_pkg::KIND_DROP, '0,
                                            ID_BITS'(i_cmd.process_id), 16'd0);
                        end else begin
                            n_ins_id    = ID_BITS'(i_cmd.process_id);
                            n_ins_prio  = i_cmd.priority_req;
                            n_post_wake = 1'b1;
                            n_k         = r_cnt;
                            n_pos       = '0;
                            n_state     = (r_mode == mcrq_pkg::MODE_PRIO && r_cnt != '0) ?
                                          S_SCAN_RD : S_INS_RD;
                        end
                    end else if (i_cmd.command <= mcrq_pkg::CMD_IDLE && cpu_ok) begin
                        n_tcpu = in_cpu;
                        if (i_cmd.command == mcrq_pkg::CMD_PREEMPT && r_running[in_cpu]
                            && (r_mode == mcrq_pkg::MODE_RR
                                || r_mode == mcrq_pkg::MODE_PRIO)) begin
                            n_cur_id   = cpu_rid;
                            n_cur_prio = cpu_rprio;
                            if (r_cnt == '0) begin
                                // Nothing to swap in: the same process runs on.
                                n_running[in_cpu] = 1'b1;
                                n_waiting[in_cpu] = 1'b0;
                                n_valid = 1'b1;
                                n_res   = f_res(mcrq_pkg::KIND_DISPATCH, in_cpu,
                                                cpu_rid, slice);
                            end else begin
                                n_pre   = 1'b1;
                                n_state = S_HEAD_USE;
                            end
                        end else begin
                            n_running[in_cpu] = 1'b0;
                            if (r_cnt == '0) begin
                                if (i_cmd.command == mcrq_pkg::CMD_IDLE) begin
                                    n_waiting[in_cpu] = 1'b1;
                                end else begin
                                    n_waiting[in_cpu] = 1'b0;
                                    n_valid = 1'b1;
                                    n_res   = f_res(mcrq_pkg::KIND_IDLE, in_cpu,
                                                    '0, slice);
                                end
                            end else begin
                                n_pre   = 1'b0;
                                n_state = S_HEAD_USE;
                            end
                        end
                    end
                end
            end

            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end

            S_SCAN_CMP: begin
                // The first entry from the head that ranks below the new one
                // marks the insert point; otherwise it goes at the tail.
                if (h_prio < r_ins_prio) begin
                    n_state = S_INS_RD;
                end else begin
                    n_pos   = r_pos + CNTW'(1);
                    n_state = (r_pos + CNTW'(1) == r_k) ? S_INS_RD : S_SCAN_RD;
                end
            end

            S_INS_RD: begin
                // Place the new entry at once outside priority mode, else once the walk reaches the insert point.
                if (r_mode != mcrq_pkg::MODE_PRIO || r_k == r_pos) begin
                    ram_we  = 1'b1;
                    n_cnt   = r_cnt + CNTW'(1);
                    n_state = r_post_wake ? S_WAKE_POST : S_IDLE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                // Entry behind the insert point moves one place towards the tail.
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_k       = r_k - CNTW'(1);
                n_state   = S_INS_RD;
            end

            S_WAKE_POST: begin
                if (wv != '0) begin
                    n_tcpu  = widx;
                    n_pre   = 1'b0;
                    n_state = S_HEAD_USE;
                end else if (r_mode != mcrq_pkg::MODE_PRIO
                             || !(&(r_running | ~act))) begin
                    n_state = S_IDLE;
                end else begin
                    n_ci    = '0;
                    n_min   = {1'b1, {PB{1'b0}}};
                    n_best  = '0;
                    n_state = S_MIN;
                end
            end

            S_MIN: begin
                // One CPU per cycle through the shared compare.
                if ({1'b0, cpu_rprio} < r_min) begin
                    m = {1'b0, cpu_rprio};
                    b = r_ci;
                end
                n_min  = m;
                n_best = b;
                n_ci   = r_ci + CW'(1);
                if (32'(r_ci) == 32'(n_eff) - 1) begin
                    n_state = S_IDLE;
                    if (m < {1'b0, r_ins_prio}) begin
                        n_valid = 1'b1;
                        n_res   = f_res(mcrq_pkg::KIND_PREEMPT, b, '0, 16'd0);
                    end
                end
            end

            S_HEAD_USE: begin
                cpu_we = 1'b1;
                n_running[r_tcpu] = 1'b1;
                n_waiting[r_tcpu] = 1'b0;
                n_valid = 1'b1;
                if (r_pre && r_mode == mcrq_pkg::MODE_PRIO && r_cur_prio > h_prio) begin
                    // Preempted process outranks the head and keeps the CPU.
                    n_res   = f_res(mcrq_pkg::KIND_DISPATCH, r_tcpu, r_cur_id, slice);
                    n_state = S_IDLE;
                end else begin
                    cpu_wid   = h_id;
                    cpu_wprio = h_prio;
                    n_res     = f_res(mcrq_pkg::KIND_DISPATCH, r_tcpu, h_id, slice);
                    n_head    = (32'(r_head) == QUEUE_DEPTH - 1) ? '0 : r_head + AW'(1);
                    n_cnt     = r_cnt - CNTW'(1);
                    if (r_pre) begin
                        // Requeue the preempted process: at the tail, or by sorted insert in priority mode.
                        n_ins_id    = r_cur_id;
                        n_ins_prio  = r_cur_prio;
                        n_post_wake = 1'b0;
                        n_k         = r_cnt - CNTW'(1);
                        n_pos       = '0;
                        n_state     = (r_mode == mcrq_pkg::MODE_PRIO
                                       && r_cnt != CNTW'(1)) ? S_SCAN_RD : S_INS_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_head    <= '0;
            r_running <= '0;
            r_waiting <= '0;
            r_valid   <= 1'b0;
            r_mode    <= mcrq_pkg::MODE_FIFO;
            r_slice   <= 16'd1;
            r_ccount  <= 3'd4;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_head    <= n_head;
            r_running <= n_running;
            r_waiting <= n_waiting;
            r_valid   <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    mcrq_pkg::REG_MODE:  r_mode   <= i_cfg_wdata[1:0];
                    mcrq_pkg::REG_SLICE: r_slice  <= i_cfg_wdata;
                    mcrq_pkg::REG_CPUS:  r_ccount <= i_cfg_wdata[2:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_pos       <= n_pos;
        r_ins_id    <= n_ins_id;
        r_ins_prio  <= n_ins_prio;
        r_post_wake <= n_post_wake;
        r_pre       <= n_pre;
        r_cur_id    <= n_cur_id;
        r_cur_prio  <= n_cur_prio;
        r_tcpu      <= n_tcpu;
        r_ci        <= n_ci;
        r_min       <= n_min;
        r_best      <= n_best;
        r_res       <= n_res;
        if (cpu_we) begin
            r_proc[cpu_widx]  <= cpu_wid;
            r_cprio[cpu_widx] <= cpu_wprio;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTH
    // The fill count never passes the queue depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    // A CPU never both runs a process and waits for one.
    a_run_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running & r_waiting) == '0)
        else $error("CPU running and waiting at once");

    // A wake-up on a full queue is dropped in the next cycle.
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.command == mcrq_pkg::CMD_WAKE
         && r_cnt == CNTW'(QUEUE_DEPTH))
        |=> (o_valid && o_res.result_kind == mcrq_pkg::KIND_DROP && !busy))
        else $error("full-queue wake-up not dropped");

    // Every shift step follows the read of the entry it moves.
    a_cmp_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> $past(r_state == S_INS_RD))
        else $error("insert compare without a read");
`endif

endmodule

### rtl/mcrq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcrq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
